### sv/dmac_pkg.sv
// Shared definitions for the four-channel DMA controller core.
// Holds command codes, control register bit positions and the stream layout.
// No dependencies.
package dmac_pkg;

   // Number of channels that are implemented. Register slots always number four.
   localparam int NUM_CHANNELS = 4;
   localparam int CHAN_SLOTS   = 4;

   // Stream widths: fields packed from the lowest bit up, padded to whole bytes.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 112;

   // Bus commands.
   typedef enum logic [3:0] {
      CMD_SRC_LO  = 4'd0,
      CMD_SRC_HI  = 4'd1,
      CMD_DST_LO  = 4'd2,
      CMD_DST_HI  = 4'd3,
      CMD_COUNT   = 4'd4,
      CMD_CONTROL = 4'd5,
      CMD_READ    = 4'd6,
      CMD_VBLANK  = 4'd7,
      CMD_HBLANK  = 4'd8,
      CMD_TICK    = 4'd9
   } cmd_type;

   // Register read-back selectors.
   typedef enum logic [1:0] {
      SEL_SOURCE  = 2'd0,
      SEL_DEST    = 2'd1,
      SEL_COUNT   = 2'd2,
      SEL_CONTROL = 2'd3
   } sel_type;

   // Start timing codes.
   typedef enum logic [1:0] {
      TIMING_NOW    = 2'd0,
      TIMING_VBLANK = 2'd1,
      TIMING_HBLANK = 2'd2,
      TIMING_SPECIAL = 2'd3
   } timing_type;

   // Address step modes.
   typedef enum logic [1:0] {
      STEP_INC    = 2'd0,
      STEP_DEC    = 2'd1,
      STEP_FIXED  = 2'd2,
      STEP_RELOAD = 2'd3
   } step_type;

   // Control register bit positions.
   localparam int CTL_ENABLE = 15;
   localparam int CTL_IRQ    = 14;
   localparam int CTL_TIM_HI = 13;
   localparam int CTL_TIM_LO = 12;
   localparam int CTL_WIDE   = 10;
   localparam int CTL_REPEAT = 9;
   localparam int CTL_SRC_HI = 8;
   localparam int CTL_SRC_LO = 7;
   localparam int CTL_DST_HI = 6;
   localparam int CTL_DST_LO = 5;

   // Unit counts loaded for a zero count register.
   localparam logic [16:0] ZERO_COUNT_UNITS      = 17'h04000;
   localparam logic [16:0] ZERO_COUNT_UNITS_LAST = 17'h10000;
   localparam logic [1:0]  LAST_CHANNEL          = 2'd3;

   // Sequencing commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the incoming transfer
      logic execute;   // perform the captured command and load the result
   } dmac_cmd_type;

endpackage

### sv/dmac_ctrl.sv
// Controller state machine of the DMA controller core.
// Sequences capture and execution and owns the result valid flag.
// Depends on dmac_pkg.
module dmac_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output dmac_pkg::dmac_cmd_type dp_cmd
);
   import dmac_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;

   // Next state: take one transfer, then execute it once the result slot is free.
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      dp_cmd   = '0;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               dp_cmd.capture = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!valid_ff || rsp_tready) begin
               dp_cmd.execute = 1'b1;
               valid_in       = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

endmodule

### sv/dmac_datapath.sv
// Datapath of the DMA controller core: channel registers, working addresses,
// the tick step with its priority pick, and the result register.
// Depends on dmac_pkg.
module dmac_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  dmac_pkg::dmac_cmd_type              dp_cmd,
   input  logic [dmac_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [dmac_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import dmac_pkg::*;

   // Captured request fields.
   logic [3:0]  cmd_ff;
   logic [1:0]  chan_ff;
   logic [1:0]  sel_ff;
   logic [15:0] wdata_ff;

   // Channel state.
   logic [31:0] src_ff   [CHAN_SLOTS], src_in   [CHAN_SLOTS];
   logic [31:0] dst_ff   [CHAN_SLOTS], dst_in   [CHAN_SLOTS];
   logic [15:0] cnt_ff   [CHAN_SLOTS], cnt_in   [CHAN_SLOTS];
   logic [15:0] ctl_ff   [CHAN_SLOTS], ctl_in   [CHAN_SLOTS];
   logic [31:0] wsrc_ff  [CHAN_SLOTS], wsrc_in  [CHAN_SLOTS];
   logic [31:0] wdst_ff  [CHAN_SLOTS], wdst_in  [CHAN_SLOTS];
   logic [16:0] units_ff [CHAN_SLOTS], units_in [CHAN_SLOTS];
   logic [CHAN_SLOTS-1:0] pend_ff, pend_in;

   // Result fields.
   logic [31:0] rd_in, xsrc_in, xdst_in;
   logic        xvalid_in, xwide_in;
   logic [3:0]  irq_in;
   logic [RSP_DATA_W-1:0] rsp_ff;

   // Tick step working values.
   logic        found;
   logic [1:0]  pick;
   logic [15:0] pctl;
   logic [16:0] units_dec;

   function automatic logic chan_ok(input logic [1:0] c);
      return 32'(c) < NUM_CHANNELS;
   endfunction

   function automatic logic [16:0] start_units(input logic [1:0] c, input logic [15:0] n);
      logic [16:0] u;
      u = {1'b0, n};
      if (n == 16'd0) begin
         u = (c == LAST_CHANNEL) ? ZERO_COUNT_UNITS_LAST : ZERO_COUNT_UNITS;
      end
      return u;
   endfunction

   function automatic logic [31:0] step_addr(input logic [31:0] a, input logic [1:0] mode,
                                             input logic wide);
      logic [31:0] size;
      logic [31:0] r;
      size = wide ? 32'd4 : 32'd2;
      case (mode)
         STEP_DEC:   r = a - size;
         STEP_FIXED: r = a;
         default:    r = a + size;
      endcase
      return r;
   endfunction

   // Capture an accepted request.
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff   <= req_tdata[3:0];
         chan_ff  <= req_tdata[5:4];
         sel_ff   <= req_tdata[7:6];
         wdata_ff <= req_tdata[23:8];
      end
   end

   // Command execution: next channel state and the result fields.
   always_comb begin
      src_in    = src_ff;
      dst_in    = dst_ff;
      cnt_in    = cnt_ff;
      ctl_in    = ctl_ff;
      wsrc_in   = wsrc_ff;
      wdst_in   = wdst_ff;
      units_in  = units_ff;
      pend_in   = pend_ff;
      rd_in     = '0;
      xvalid_in = 1'b0;
      xsrc_in   = '0;
      xdst_in   = '0;
      xwide_in  = 1'b0;
      irq_in    = '0;
      found     = 1'b0;
      pick      = '0;

      // Lowest-numbered pending channel wins the tick.
      for (int c = 0; c < CHAN_SLOTS; c++) begin
         if (chan_ok(2'(c)) && pend_ff[c] && !found) begin
            found = 1'b1;
            pick  = 2'(c);
         end
      end
      pctl      = ctl_ff[pick];
      units_dec = units_ff[pick] - 17'd1;

      case (cmd_ff)
         CMD_SRC_LO: begin
            if (chan_ok(chan_ff)) src_in[chan_ff] = {src_ff[chan_ff][31:16], wdata_ff};
         end
         CMD_SRC_HI: begin
            if (chan_ok(chan_ff)) src_in[chan_ff] = {wdata_ff, src_ff[chan_ff][15:0]};
         end
         CMD_DST_LO: begin
            if (chan_ok(chan_ff)) dst_in[chan_ff] = {dst_ff[chan_ff][31:16], wdata_ff};
         end
         CMD_DST_HI: begin
            if (chan_ok(chan_ff)) dst_in[chan_ff] = {wdata_ff, dst_ff[chan_ff][15:0]};
         end
         CMD_COUNT: begin
            if (chan_ok(chan_ff)) cnt_in[chan_ff] = wdata_ff;
         end
         CMD_CONTROL: begin
            if (chan_ok(chan_ff)) begin
               ctl_in[chan_ff] = wdata_ff;
               if (!wdata_ff[CTL_ENABLE]) begin
                  pend_in[chan_ff] = 1'b0;
               end else if (!ctl_ff[chan_ff][CTL_ENABLE]) begin
                  // Rising enable latches the working addresses.
                  wsrc_in[chan_ff] = src_ff[chan_ff];
                  wdst_in[chan_ff] = dst_ff[chan_ff];
                  if (wdata_ff[CTL_TIM_HI:CTL_TIM_LO] == TIMING_NOW) begin
                     units_in[chan_ff] = start_units(chan_ff, cnt_ff[chan_ff]);
                     pend_in[chan_ff]  = 1'b1;
                  end
               end
            end
         end
         CMD_READ: begin
            if (chan_ok(chan_ff)) begin
               case (sel_ff)
                  SEL_SOURCE: rd_in = src_ff[chan_ff];
                  SEL_DEST:   rd_in = dst_ff[chan_ff];
                  SEL_COUNT:  rd_in = {16'd0, cnt_ff[chan_ff]};
                  default:    rd_in = {16'd0, ctl_ff[chan_ff]};
               endcase
            end
         end
         CMD_VBLANK, CMD_HBLANK: begin
            // Start every idle enabled channel whose timing matches this blank.
            for (int c = 0; c < CHAN_SLOTS; c++) begin
               if (chan_ok(2'(c)) && ctl_ff[c][CTL_ENABLE] && !pend_ff[c] &&
                   ((cmd_ff == CMD_VBLANK &&
                     ctl_ff[c][CTL_TIM_HI:CTL_TIM_LO] == TIMING_VBLANK) ||
                    (cmd_ff == CMD_HBLANK &&
                     ctl_ff[c][CTL_TIM_HI:CTL_TIM_LO] == TIMING_HBLANK))) begin
                  units_in[c] = start_units(2'(c), cnt_ff[c]);
                  pend_in[c]  = 1'b1;
               end
            end
         end
         CMD_TICK: begin
            if (found) begin
               xvalid_in      = 1'b1;
               xwide_in       = pctl[CTL_WIDE];
               xsrc_in        = wsrc_ff[pick];
               xdst_in        = wdst_ff[pick];
               wsrc_in[pick]  = step_addr(wsrc_ff[pick], pctl[CTL_SRC_HI:CTL_SRC_LO],
                                          pctl[CTL_WIDE]);
               wdst_in[pick]  = step_addr(wdst_ff[pick], pctl[CTL_DST_HI:CTL_DST_LO],
                                          pctl[CTL_WIDE]);
               units_in[pick] = units_dec;
               // Last unit: interrupt if enabled, then repeat (not for immediate timing) or drop the enable.
               if (units_dec == 17'd0) begin
                  pend_in[pick] = 1'b0;
                  irq_in[pick]  = pctl[CTL_IRQ];
                  if (pctl[CTL_REPEAT] && pctl[CTL_TIM_HI:CTL_TIM_LO] != TIMING_NOW) begin
                     if (pctl[CTL_DST_HI:CTL_DST_LO] == STEP_RELOAD) begin
                        wdst_in[pick] = dst_ff[pick];
                     end
                  end else begin
                     ctl_in[pick] = {1'b0, pctl[14:0]};
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Channel state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHAN_SLOTS; c++) begin
            src_ff[c]   <= '0;
            dst_ff[c]   <= '0;
            cnt_ff[c]   <= '0;
            ctl_ff[c]   <= '0;
            wsrc_ff[c]  <= '0;
            wdst_ff[c]  <= '0;
            units_ff[c] <= '0;
         end
         pend_ff <= '0;
      end else if (dp_cmd.execute) begin
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         cnt_ff   <= cnt_in;
         ctl_ff   <= ctl_in;
         wsrc_ff  <= wsrc_in;
         wdst_ff  <= wdst_in;
         units_ff <= units_in;
         pend_ff  <= pend_in;
      end
   end

   // Result register, packed from the lowest bit up.
   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         rsp_ff <= {6'd0, pend_in, irq_in, xwide_in, xdst_in, xsrc_in, xvalid_in, rd_in};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

### sv/four_channel_dma_controller_core.sv
// Four-channel DMA address engine: bus commands in, one result per command out.
// Depends on dmac_pkg, dmac_ctrl and dmac_datapath.
//
// Usage: each transfer on the req_ stream carries one bus command (register
// write, register read, vblank, hblank or tick). Every command produces exactly
// one transfer on the rsp_ stream with the read data, the issued DMA unit (if
// any, on a tick), the per-channel interrupt bits and the pending mask.
// Sequencing: a command is captured, then executed once the result register is
// free; at execution its result is registered and rsp_tvalid rises. The
// controller alternates between capture and execution, so no new command is
// taken before the last has executed, and channel state is updated once per command.
// Reset: synchronous, active high; clears all channel registers, working
// addresses, unit counts and pending bits, and clears rsp_tvalid; the result data register is not reset.
// Back-pressure: while rsp_tready is low the result is held; one further
// command may be captured, and it executes as soon as the held result is taken.
module four_channel_dma_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   // command[3:0], channel[5:4], reg_select[7:6], write_data[23:8]
   input  logic [dmac_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // read_data[31:0], xfer_valid[32], xfer_src_addr[64:33], xfer_dst_addr[96:65],
   // xfer_wide[97], irq_raise[101:98], busy_mask[105:102], zero padding above
   output logic [dmac_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);
   import dmac_pkg::*;

   dmac_cmd_type dp_cmd;

   // Sequencing and handshakes.
   dmac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   // Channel registers and address stepping.
   dmac_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
